@@ sv/cclb_pkg.sv @@
package cclb_pkg;

    // Character codes the lexer recognises
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Input kind codes
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Default depth of the queue between classifier and emitter
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       text_end;
    } out_t;

    // One classified request: one or two results
    typedef struct packed {
        logic two;
        out_t first;
        out_t second;
    } act_t;

    // Queue status seen by the front, the back and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ sv/cclb_front.sv @@
module cclb_front
    import cclb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  in_t     in_data,
    input  q_stat_t q_stat,
    output logic    push,
    output act_t    push_act
);

    // Lexer state codes
    localparam logic [3:0] ST_NORMAL     = 4'd0;
    localparam logic [3:0] ST_SLASH      = 4'd1;
    localparam logic [3:0] ST_LINE       = 4'd2;
    localparam logic [3:0] ST_BLOCK      = 4'd3;
    localparam logic [3:0] ST_BLOCK_STAR = 4'd4;
    localparam logic [3:0] ST_STR        = 4'd5;
    localparam logic [3:0] ST_STR_ESC    = 4'd6;
    localparam logic [3:0] ST_CHR        = 4'd7;
    localparam logic [3:0] ST_CHR_ESC    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;
    logic       has_result;
    logic [7:0] c;
    logic [7:0] blanked;

    assign in_ready = ~q_stat.full;
    assign accept   = in_valid & in_ready;
    assign push     = accept & has_result;
    assign c        = in_data.text_byte;
    assign blanked  = (c == CH_NL) ? CH_NL : CH_SPACE;

    // Classify the request against the current lexer state
    always_comb
    begin
        state_next      = state_reg;
        has_result      = 1'b1;
        push_act.two    = 1'b0;
        push_act.first  = '{out_byte: blanked, byte_valid: 1'b1,
                            last_of_run: 1'b1, text_end: 1'b0};
        push_act.second = '{out_byte: c, byte_valid: 1'b1,
                            last_of_run: 1'b1, text_end: 1'b0};
        if (in_data.kind == KIND_END)
        begin
            // Flush a held slash, close whatever is open
            push_act.first.out_byte   = (state_reg == ST_SLASH) ? CH_SLASH : CH_NUL;
            push_act.first.byte_valid = (state_reg == ST_SLASH);
            push_act.first.text_end   = 1'b1;
            state_next                = ST_NORMAL;
        end
        else
        begin
            case (state_reg)
                ST_SLASH:
                begin
                    push_act.two                = 1'b1;
                    push_act.first.last_of_run  = 1'b0;
                    if ((c == CH_SLASH) || (c == CH_STAR))
                    begin
                        push_act.first.out_byte  = CH_SPACE;
                        push_act.second.out_byte = CH_SPACE;
                        state_next = (c == CH_SLASH) ? ST_LINE : ST_BLOCK;
                    end
                    else
                    begin
                        push_act.first.out_byte = CH_SLASH;
                        state_next              = ST_NORMAL;
                    end
                end
                ST_LINE:
                begin
                    if (c == CH_NL)
                        state_next = ST_NORMAL;
                end
                ST_BLOCK:
                begin
                    if (c == CH_STAR)
                        state_next = ST_BLOCK_STAR;
                end
                ST_BLOCK_STAR:
                begin
                    if (c == CH_SLASH)
                        state_next = ST_NORMAL;
                    else if (c != CH_STAR)
                        state_next = ST_BLOCK;
                end
                ST_STR:
                begin
                    if (c == CH_BSLASH)
                        state_next = ST_STR_ESC;
                    else if (c == CH_DQUOTE)
                        state_next = ST_NORMAL;
                end
                ST_CHR:
                begin
                    if (c == CH_BSLASH)
                        state_next = ST_CHR_ESC;
                    else if (c == CH_SQUOTE)
                        state_next = ST_NORMAL;
                end
                ST_STR_ESC:
                    state_next = ST_STR;
                ST_CHR_ESC:
                    state_next = ST_CHR;
                default:
                begin
                    // Normal text; unused codes behave the same
                    if (c == CH_SLASH)
                    begin
                        has_result = 1'b0;
                        state_next = ST_SLASH;
                    end
                    else if (c == CH_DQUOTE)
                    begin
                        push_act.first.out_byte = CH_SPACE;
                        state_next              = ST_STR;
                    end
                    else if (c == CH_SQUOTE)
                    begin
                        push_act.first.out_byte = CH_SPACE;
                        state_next              = ST_CHR;
                    end
                    else
                    begin
                        push_act.first.out_byte = c;
                        state_next              = ST_NORMAL;
                    end
                end
            endcase
        end
    end

    // Advance the lexer on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_NORMAL;
        else if (accept)
            state_reg <= state_next;
    end

endmodule

@@ sv/cclb_queue.sv @@
module cclb_queue
    import cclb_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  act_t    push_act,
    input  logic    pop,
    output act_t    head_act,
    output q_stat_t q_stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    act_t            slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign q_stat.full  = (count_reg == FullCnt);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push & ~q_stat.full;
    assign do_pop       = pop & ~q_stat.empty;
    assign head_act     = slot_reg[rd_ptr_reg];

    // Store incoming requests
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_act;
    end

    // Move pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ sv/cclb_back.sv @@
module cclb_back
    import cclb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_stat_t q_stat,
    input  act_t    head_act,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output out_t    out_data
);

    logic out_valid_reg;
    out_t out_reg;
    logic phase_reg;
    logic phase_next;
    logic load;

    // Emit one result per cycle whenever the queue holds a request and the output register is free
    assign load       = ~q_stat.empty & (~out_valid_reg | out_ready);
    assign pop        = load & ~(head_act.two & ~phase_reg);
    assign phase_next = load ? (head_act.two & ~phase_reg) : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= phase_reg ? head_act.second : head_act.first;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ sv/c_comment_literal_blanker_core.sv @@
// Each result is registered in the queue and then in the output register before
// it is offered. Throughput: one request per cycle while the queue is not full;
// the output register emits one result per cycle while the receiver takes them,
// and a request giving two results leaves the queue with its second result.
// A request that only holds a slash gives no result.
// Reset (rst_n low, asynchronous): lexer to normal, queue empty, no result.
module c_comment_literal_blanker_core
    import cclb_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    q_stat_t q_stat;
    logic    push;
    act_t    push_act;
    logic    pop;
    act_t    head_act;

    cclb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_act (push_act)
    );

    cclb_queue #(
        .Depth (Depth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_act (push_act),
        .pop      (pop),
        .head_act (head_act),
        .q_stat   (q_stat)
    );

    cclb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_act  (head_act),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // An end-of-text answer always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_end |-> out_data.last_of_run)
        else $error("end-of-text result without last_of_run");

    // Only an end-of-text answer may carry no character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.text_end)
        else $error("empty result for a text byte");

    // Queue is never full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // A push is never issued into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

endmodule

@@ sim/cclb_blank_checker.sv @@
`timescale 1ns / 1ps

module cclb_blank_checker
    import cclb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  in_t  in_data,
    input  logic out_valid,
    input  logic out_ready,
    input  out_t out_data,
    output int   errors,
    output int   awaited
);

    // Lexer state codes of the predictor
    localparam logic [3:0] LX_NORMAL     = 4'd0;
    localparam logic [3:0] LX_SLASH      = 4'd1;
    localparam logic [3:0] LX_LINE       = 4'd2;
    localparam logic [3:0] LX_BLOCK      = 4'd3;
    localparam logic [3:0] LX_BLOCK_STAR = 4'd4;
    localparam logic [3:0] LX_STR        = 4'd5;
    localparam logic [3:0] LX_STR_ESC    = 4'd6;
    localparam logic [3:0] LX_CHR        = 4'd7;
    localparam logic [3:0] LX_CHR_ESC    = 4'd8;

    logic [3:0] lexer;
    out_t       blanked_q [$];

    function automatic out_t make_result(input logic [7:0] ch, input logic valid,
                                         input logic at_end);
        out_t r;
        r.out_byte    = ch;
        r.byte_valid  = valid;
        r.last_of_run = 1'b0;
        r.text_end    = at_end;
        return r;
    endfunction

    // Advance the lexer by one request and queue the blanked characters it gives
    function automatic void blank_request(input in_t req);
        out_t       got [$];
        logic [7:0] c;
        logic [7:0] blanked;
        c       = req.text_byte;
        blanked = (c == CH_NL) ? CH_NL : CH_SPACE;
        if (req.kind == KIND_END)
        begin
            if (lexer == LX_SLASH)
                got.push_back(make_result(CH_SLASH, 1'b1, 1'b1));
            else
                got.push_back(make_result(CH_NUL, 1'b0, 1'b1));
            lexer = LX_NORMAL;
        end
        else
        begin
            case (lexer)
                LX_SLASH:
                begin
                    if (c == CH_SLASH || c == CH_STAR)
                    begin
                        got.push_back(make_result(CH_SPACE, 1'b1, 1'b0));
                        got.push_back(make_result(CH_SPACE, 1'b1, 1'b0));
                        lexer = (c == CH_SLASH) ? LX_LINE : LX_BLOCK;
                    end
                    else
                    begin
                        got.push_back(make_result(CH_SLASH, 1'b1, 1'b0));
                        got.push_back(make_result(c, 1'b1, 1'b0));
                        lexer = LX_NORMAL;
                    end
                end
                LX_LINE:
                begin
                    got.push_back(make_result(blanked, 1'b1, 1'b0));
                    if (c == CH_NL)
                        lexer = LX_NORMAL;
                end
                LX_BLOCK:
                begin
                    got.push_back(make_result(blanked, 1'b1, 1'b0));
                    if (c == CH_STAR)
                        lexer = LX_BLOCK_STAR;
                end
                LX_BLOCK_STAR:
                begin
                    got.push_back(make_result(blanked, 1'b1, 1'b0));
                    if (c == CH_SLASH)
                        lexer = LX_NORMAL;
                    else if (c != CH_STAR)
                        lexer = LX_BLOCK;
                end
                LX_STR:
                begin
                    got.push_back(make_result(blanked, 1'b1, 1'b0));
                    if (c == CH_BSLASH)
                        lexer = LX_STR_ESC;
                    else if (c == CH_DQUOTE)
                        lexer = LX_NORMAL;
                end
                LX_CHR:
                begin
                    got.push_back(make_result(blanked, 1'b1, 1'b0));
                    if (c == CH_BSLASH)
                        lexer = LX_CHR_ESC;
                    else if (c == CH_SQUOTE)
                        lexer = LX_NORMAL;
                end
                LX_STR_ESC:
                begin
                    got.push_back(make_result(blanked, 1'b1, 1'b0));
                    lexer = LX_STR;
                end
                LX_CHR_ESC:
                begin
                    got.push_back(make_result(blanked, 1'b1, 1'b0));
                    lexer = LX_CHR;
                end
                default:
                begin
                    // hold a slash back until the next character decides
                    if (c == CH_SLASH)
                    begin
                        lexer = LX_SLASH;
                    end
                    else if (c == CH_DQUOTE)
                    begin
                        got.push_back(make_result(CH_SPACE, 1'b1, 1'b0));
                        lexer = LX_STR;
                    end
                    else if (c == CH_SQUOTE)
                    begin
                        got.push_back(make_result(CH_SPACE, 1'b1, 1'b0));
                        lexer = LX_CHR;
                    end
                    else
                    begin
                        got.push_back(make_result(c, 1'b1, 1'b0));
                        lexer = LX_NORMAL;
                    end
                end
            endcase
        end
        if (got.size() > 0)
            got[got.size() - 1].last_of_run = 1'b1;
        foreach (got[i])
            blanked_q.push_back(got[i]);
    endfunction

    // Compare each accepted result first, then predict for the accepted request
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            blanked_q.delete();
            lexer   = LX_NORMAL;
            errors  = 0;
            awaited = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (blanked_q.size() == 0)
                begin
                    $error("result with nothing expected: out_byte %h", out_data.out_byte);
                    errors++;
                end
                else
                begin
                    want = blanked_q.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h",
                               want.out_byte, out_data.out_byte);
                        errors++;
                    end
                    if (out_data.byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b",
                               want.byte_valid, out_data.byte_valid);
                        errors++;
                    end
                    if (out_data.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, out_data.last_of_run);
                        errors++;
                    end
                    if (out_data.text_end !== want.text_end)
                    begin
                        $error("text_end: expected %b, got %b",
                               want.text_end, out_data.text_end);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                blank_request(in_data);
            awaited = blanked_q.size();
        end
    end

endmodule

@@ sim/tb_c_comment_literal_blanker_core.sv @@
`timescale 1ns / 1ps

module tb_c_comment_literal_blanker_core
    import cclb_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    int   errors;
    int   awaited;
    int   sent;
    int   cycles;
    bit   tx_idle_on;

    c_comment_literal_blanker_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    cclb_blank_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .errors   (errors),
        .awaited  (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one request from a falling edge and hold it until accepted
    task automatic send_request(input logic kind, input logic [7:0] ch);
        while (tx_idle_on && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{kind: kind, text_byte: ch};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Bias comment and literal bodies towards the characters that move the lexer
    function automatic logic [7:0] pick_body_byte();
        case ($urandom_range(7))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2:       return CH_BSLASH;
            3:       return CH_NL;
            4:       return CH_DQUOTE;
            5:       return CH_SQUOTE;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off to fill the block, a clean stretch, then random stalls again
    initial
    begin
        int rx_cycle;
        out_ready = 1'b0;
        rx_cycle  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle >= 150 && rx_cycle < 250)
                out_ready <= 1'b0;
            else if (rx_cycle >= 250 && rx_cycle < 500)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 19);
        end
    end

    // Abort a run that hangs
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        in_t opening [24];
        int  len;
        opening = '{
            // plain text around a slash that is not a comment
            {KIND_TEXT, 8'h61}, {KIND_TEXT, CH_SLASH}, {KIND_TEXT, 8'h62},
            // line comment closed by a newline
            {KIND_TEXT, CH_SLASH}, {KIND_TEXT, CH_SLASH}, {KIND_TEXT, CH_NL},
            // block comment closed after a star
            {KIND_TEXT, CH_SLASH}, {KIND_TEXT, CH_STAR}, {KIND_TEXT, CH_STAR},
            {KIND_TEXT, CH_SLASH},
            // string with an escaped quote
            {KIND_TEXT, CH_DQUOTE}, {KIND_TEXT, CH_BSLASH}, {KIND_TEXT, CH_DQUOTE},
            {KIND_TEXT, CH_DQUOTE},
            // char literal holding a zero byte
            {KIND_TEXT, CH_SQUOTE}, {KIND_TEXT, 8'h00}, {KIND_TEXT, CH_SQUOTE},
            // slash then quote does not open a string
            {KIND_TEXT, CH_SLASH}, {KIND_TEXT, CH_DQUOTE},
            // end of text flushes a held slash
            {KIND_TEXT, CH_SLASH}, {KIND_END, 8'hFF},
            // end of text closes an open string
            {KIND_TEXT, 8'hFF}, {KIND_TEXT, CH_DQUOTE}, {KIND_END, 8'h00}
        };
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        tx_idle_on = 1'b1;
        sent       = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            send_request(opening[i].kind, opening[i].text_byte);

        // Random fragments of C-like text with noise and early ends
        while (sent < 550)
        begin
            tx_idle_on = !(sent >= 300 && sent < 420);
            case ($urandom_range(9))
                0: send_request(KIND_TEXT, 8'($urandom_range(1, 255)));
                1, 2: send_request(KIND_TEXT, 8'($urandom_range(8'h20, 8'h7E)));
                3:
                begin
                    send_request(KIND_TEXT, CH_SLASH);
                    send_request(KIND_TEXT, CH_SLASH);
                    len = $urandom_range(0, 6);
                    repeat (len) send_request(KIND_TEXT, pick_body_byte());
                    send_request(KIND_TEXT, CH_NL);
                end
                4:
                begin
                    send_request(KIND_TEXT, CH_SLASH);
                    send_request(KIND_TEXT, CH_STAR);
                    len = $urandom_range(0, 6);
                    repeat (len) send_request(KIND_TEXT, pick_body_byte());
                    send_request(KIND_TEXT, CH_STAR);
                    send_request(KIND_TEXT, CH_SLASH);
                end
                5:
                begin
                    send_request(KIND_TEXT, CH_DQUOTE);
                    len = $urandom_range(0, 6);
                    repeat (len) send_request(KIND_TEXT, pick_body_byte());
                    send_request(KIND_TEXT, CH_DQUOTE);
                end
                6:
                begin
                    send_request(KIND_TEXT, CH_SQUOTE);
                    if ($urandom_range(1) == 0)
                        send_request(KIND_TEXT, CH_BSLASH);
                    send_request(KIND_TEXT, 8'($urandom_range(1, 255)));
                    send_request(KIND_TEXT, CH_SQUOTE);
                end
                7:
                begin
                    send_request(KIND_TEXT, CH_SLASH);
                    send_request(KIND_TEXT, pick_body_byte());
                end
                8: send_request(KIND_TEXT, CH_NL);
                default: send_request(KIND_END, 8'($urandom_range(255)));
            endcase
        end
        in_valid <= 1'b0;

        // Drain the expected results, then keep the clock running so that a stray result is caught
        while (awaited != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
